/* rtl/core/rbci_pkg.sv */
// Package with the shared types and codes of the ring buffer claim/ack index unit.
`timescale 1ns / 1ps

package rbci_pkg;

  // Operation codes carried in the kind field of an input word.
  localparam logic [2:0] KIND_PUT_CLAIM = 3'd0;
  localparam logic [2:0] KIND_PUT_ACK   = 3'd1;
  localparam logic [2:0] KIND_GET_CLAIM = 3'd2;
  localparam logic [2:0] KIND_GET_ACK   = 3'd3;
  localparam logic [2:0] KIND_CLEAR     = 3'd4;

  // Status codes of a result word.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Capacity after reset.
  localparam logic [16:0] CAPACITY_RESET = 17'h10000;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL,
    ST_WRAP,
    ST_LIMIT,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rel;
    logic wrap;
    logic limit;
    logic commit;
  } cmd_t;

endpackage

/* rtl/core/ring_buffer_claim_ack_index_unit.sv */
// Each accepted word is walked by the sequencer through the shared datapath in the steps
// load, rel, wrap, limit and commit; no new word is taken until the commit, and a stalled
// result holds the commit step.
// Reset (rst, synchronous): counters clear, capacity returns to 65536, no result pending.
// A clear word also empties all six counters but keeps the capacity.
`timescale 1ns / 1ps

module ring_buffer_claim_ack_index_unit
  import rbci_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [16:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] granted,
  output logic [15:0] offset,
  output logic        status
);

  cmd_t cmd;

  // Sequencer.
  rbci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Counters and arithmetic.
  rbci_datapath #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .kind        (kind),
    .amount      (amount),
    .granted     (granted),
    .offset      (offset),
    .status      (status)
  );

endmodule

/* rtl/core/rbci_ctrl.sv */
// Controller state machine that steps one word through the datapath.
`timescale 1ns / 1ps

module rbci_ctrl
  import rbci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_REL;
        end
      end
      ST_REL: begin
        cmd.rel    = 1'b1;
        state_next = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = ST_LIMIT;
      end
      ST_LIMIT: begin
        cmd.limit  = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The result word stays valid until it is taken.
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* rtl/core/rbci_datapath.sv */
// Datapath with the zone counters, the capacity register and the claim/ack arithmetic.
`timescale 1ns / 1ps

module rbci_datapath
  import rbci_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic [2:0]  kind,
  input  logic [16:0] amount,
  output logic [16:0] granted,
  output logic [15:0] offset,
  output logic        status
);

  localparam logic [31:0] MAX_CAP = 32'(MAX_CAPACITY);

  logic [16:0] capacity;
  logic [31:0] put_base, put_head, put_tail;
  logic [31:0] get_base, get_head, get_tail;

  // Working registers of the current word.
  logic [2:0]  kind_r;
  logic [16:0] amt_r;
  logic [16:0] cap_r;
  logic [31:0] rel, used, diff, tail_n;
  logic [31:0] rel_c, base_c, room, tail_rel;
  logic        reject;
  logic [16:0] g1;
  logic [15:0] off_r;
  logic        bump;
  logic [31:0] base_bump;

  logic [16:0] cap_eff;
  logic        is_get;
  logic [31:0] zbase, zhead, ztail;
  logic [31:0] cap32, amt32;
  logic        wrap;
  logic [31:0] lim;
  logic [16:0] g;

  // Effective capacity, held within 1 to the maximum.
  always_comb begin
    if (capacity == 17'd0) begin
      cap_eff = 17'd1;
    end else if ({15'd0, capacity} > MAX_CAP) begin
      cap_eff = MAX_CAP[16:0];
    end else begin
      cap_eff = capacity;
    end
  end

  // Zone selection follows the kind code.
  assign is_get = kind_r[1];
  assign zbase  = is_get ? get_base : put_base;
  assign zhead  = is_get ? get_head : put_head;
  assign ztail  = is_get ? get_tail : put_tail;
  assign cap32  = {15'd0, cap_r};
  assign amt32  = {15'd0, amt_r};
  assign wrap   = rel >= cap32;
  assign lim    = cap32 - rel_c;
  assign g      = ({15'd0, g1} < room) ? g1 : room[16:0];

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Working registers, one group per step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      amt_r  <= amount;
      cap_r  <= cap_eff;
    end
    if (cmd.rel) begin
      rel    <= zhead - zbase;
      used   <= put_head - get_tail;
      diff   <= zhead - ztail;
      tail_n <= ztail + amt32;
    end
    if (cmd.wrap) begin
      rel_c    <= wrap ? rel - cap32 : rel;
      base_c   <= wrap ? zbase + cap32 : zbase;
      room     <= is_get ? put_tail - get_head : cap32 - used;
      reject   <= amt32 > diff;
      tail_rel <= tail_n - zbase;
    end
    if (cmd.limit) begin
      g1        <= (amt32 < lim) ? amt_r : lim[16:0];
      off_r     <= 16'(zhead - base_c);
      bump      <= tail_rel >= cap32;
      base_bump <= zbase + cap32;
    end
  end

  // Counter updates at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      put_base <= '0;
      put_head <= '0;
      put_tail <= '0;
      get_base <= '0;
      get_head <= '0;
      get_tail <= '0;
    end else if (cmd.commit) begin
      unique case (kind_r)
        KIND_PUT_CLAIM: begin
          put_head <= put_head + {15'd0, g};
        end
        KIND_GET_CLAIM: begin
          get_head <= get_head + {15'd0, g};
        end
        KIND_PUT_ACK: begin
          if (!reject) begin
            put_tail <= tail_n;
            put_head <= tail_n;
            if (bump) begin
              put_base <= base_bump;
            end
          end
        end
        KIND_GET_ACK: begin
          if (!reject) begin
            get_tail <= tail_n;
            get_head <= tail_n;
            if (bump) begin
              get_base <= base_bump;
            end
          end
        end
        KIND_CLEAR: begin
          put_base <= '0;
          put_head <= '0;
          put_tail <= '0;
          get_base <= '0;
          get_head <= '0;
          get_tail <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique case (kind_r)
        KIND_PUT_CLAIM, KIND_GET_CLAIM: begin
          granted <= g;
          offset  <= off_r;
          status  <= STATUS_OK;
        end
        KIND_PUT_ACK, KIND_GET_ACK: begin
          granted <= '0;
          offset  <= '0;
          status  <= reject ? STATUS_REJECTED : STATUS_OK;
        end
        default: begin
          granted <= '0;
          offset  <= '0;
          status  <= STATUS_OK;
        end
      endcase
    end
  end

endmodule

/* sim/ring_buffer_claim_ack_index_unit_tb.sv */
// Self-checking testbench for the ring buffer claim/ack index unit.
`timescale 1ns / 1ps

module ring_buffer_claim_ack_index_unit_tb
  import rbci_pkg::*;
();

  localparam int unsigned MAX_CAP = 65536;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [16:0] AMOUNT_ALL_ONES = 17'h1FFFF;

  // One result word as the block should present it.
  typedef struct packed {
    logic [16:0] granted;
    logic [15:0] offset;
    logic        status;
  } index_result_t;

  // Mirror of the six zone counters and the capacity, with the queue of
  // result words still owed by the block.
  class ring_counters;
    logic [31:0] cap_value;
    logic [31:0] put_base, put_head, put_tail;
    logic [31:0] get_base, get_head, get_tail;
    index_result_t owed_q[$];
    int unsigned errors, words, claims, acks, rejects;

    function new();
      cap_value = {15'd0, CAPACITY_RESET};
      clear_counters();
      errors = 0;
      words = 0;
      claims = 0;
      acks = 0;
      rejects = 0;
    endfunction

    function void clear_counters();
      put_base = '0;
      put_head = '0;
      put_tail = '0;
      get_base = '0;
      get_head = '0;
      get_tail = '0;
    endfunction

    function void set_capacity(logic [16:0] value);
      cap_value = {15'd0, value};
    endfunction

    // Capacity as the block uses it: zero acts as one, large values saturate.
    function logic [31:0] eff_cap();
      if (cap_value == 0) return 32'd1;
      if (cap_value > MAX_CAP) return MAX_CAP;
      return cap_value;
    endfunction

    // Bytes claimed but not yet acked in one zone.
    function logic [31:0] open_claim(bit on_put);
      return on_put ? put_head - put_tail : get_head - get_tail;
    endfunction

    // Claim: clamp to the room before the wrap and to free or used space.
    function logic [31:0] claim(bit on_put, logic [31:0] req, output logic [31:0] start);
      logic [31:0] cap, base, head, room, rel, g;
      cap = eff_cap();
      if (on_put) begin
        base = put_base;
        head = put_head;
        room = cap - (put_head - get_tail);
      end else begin
        base = get_base;
        head = get_head;
        room = put_tail - get_head;
      end
      rel = head - base;
      g = req;
      if (rel >= cap) begin
        base = base + cap;
        rel = rel - cap;
      end
      if (cap - rel < g) g = cap - rel;
      if (room < g) g = room;
      start = head - base;
      if (on_put) put_head = head + g;
      else get_head = head + g;
      return g;
    endfunction

    // Ack: commit up to the open claim, moving the base once past capacity.
    function logic ack(bit on_put, logic [31:0] amt);
      logic [31:0] cap, base, head, tail;
      cap = eff_cap();
      base = on_put ? put_base : get_base;
      head = on_put ? put_head : get_head;
      tail = on_put ? put_tail : get_tail;
      if (amt > head - tail) return STATUS_REJECTED;
      tail = tail + amt;
      head = tail;
      if (tail - base >= cap) base = base + cap;
      if (on_put) begin
        put_base = base;
        put_head = head;
        put_tail = tail;
      end else begin
        get_base = base;
        get_head = head;
        get_tail = tail;
      end
      return STATUS_OK;
    endfunction

    // Note an accepted input word and queue the result it owes.
    function void accept_word(logic [2:0] k, logic [16:0] a);
      index_result_t r;
      logic [31:0] start, g;
      r = '0;
      start = '0;
      words++;
      case (k)
        KIND_PUT_CLAIM, KIND_GET_CLAIM: begin
          g = claim(k == KIND_PUT_CLAIM, {15'd0, a}, start);
          r.granted = g[16:0];
          r.offset = start[15:0];
          claims++;
        end
        KIND_PUT_ACK, KIND_GET_ACK: begin
          r.status = ack(k == KIND_PUT_ACK, {15'd0, a});
          acks++;
          if (r.status == STATUS_REJECTED) rejects++;
        end
        KIND_CLEAR: clear_counters();
        default: ;
      endcase
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest owed one.
    function void compare_word(logic [16:0] g, logic [15:0] o, logic s);
      index_result_t r;
      if (owed_q.size() == 0) begin
        $error("Result word with nothing owed: granted=%0d offset=%0d status=%0d", g, o, s);
        errors++;
        return;
      end
      r = owed_q.pop_front();
      if (g !== r.granted) begin
        $error("granted: expected %0d, actual %0d", r.granted, g);
        errors++;
      end
      if (o !== r.offset) begin
        $error("offset: expected %0d, actual %0d", r.offset, o);
        errors++;
      end
      if (s !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = '0;
  logic [16:0] amount = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] granted;
  logic [15:0] offset;
  logic        status;

  ring_counters tracker;
  bit send_eager = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned settings = 1;

  ring_buffer_claim_ack_index_unit #(
    .MAX_CAPACITY(MAX_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .amount(amount),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .granted(granted),
    .offset(offset),
    .status(status)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Idle cycles before a word; eager stretches have none.
  function automatic int unsigned draw_gap(bit eager);
    return eager ? 0 : $urandom_range(0, 8);
  endfunction

  // Claim sizes: mostly within half the ring, sometimes the whole ring or wild.
  function automatic logic [16:0] claim_size(logic [31:0] cap);
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return 17'($urandom() & AMOUNT_ALL_ONES);
    if (p < 3) return 17'((cap + $urandom_range(0, 1)) & AMOUNT_ALL_ONES);
    return 17'($urandom_range(0, cap / 2 + 1));
  endfunction

  // Ack sizes: mostly within the open claim, sometimes all of it or too much.
  function automatic logic [16:0] ack_size(logic [31:0] open);
    int unsigned p;
    logic [31:0] lim;
    logic [31:0] over;
    p = $urandom_range(0, 9);
    lim = (open > AMOUNT_ALL_ONES) ? AMOUNT_ALL_ONES : open;
    if (p == 0) begin
      if (open < AMOUNT_ALL_ONES) begin
        over = open + 1 + $urandom_range(0, 3);
        return (over > AMOUNT_ALL_ONES) ? AMOUNT_ALL_ONES : over[16:0];
      end
      return AMOUNT_ALL_ONES;
    end
    if (p == 1) return lim[16:0];
    return 17'($urandom_range(0, lim));
  endfunction

  // Present one input word and hold it until the block takes it.
  task automatic send_word(input logic [2:0] k, input logic [16:0] a);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_eager = !send_eager;
    gap = draw_gap(send_eager);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    amount <= a;
    do @(posedge clk); while (in_stall);
    tracker.accept_word(k, a);
  endtask

  // Stop sending and wait for every owed result, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.owed_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Capacity write; only issued after a drain.
  task automatic write_capacity(input logic [16:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tracker.set_capacity(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // One random word, weighted toward claim and ack sequences.
  task automatic send_random_word();
    int unsigned r;
    logic [31:0] cap;
    r = $urandom_range(0, 99);
    cap = tracker.eff_cap();
    if (r < 4) send_word(3'($urandom_range(0, 7)), 17'($urandom() & AMOUNT_ALL_ONES));
    else if (r < 30) send_word(KIND_PUT_CLAIM, claim_size(cap));
    else if (r < 52) send_word(KIND_PUT_ACK, ack_size(tracker.open_claim(1'b1)));
    else if (r < 76) send_word(KIND_GET_CLAIM, claim_size(cap));
    else if (r < 97) send_word(KIND_GET_ACK, ack_size(tracker.open_claim(1'b0)));
    else if (r < 98) send_word(KIND_CLEAR, 17'($urandom() & AMOUNT_ALL_ONES));
    else send_word(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                   17'($urandom() & AMOUNT_ALL_ONES));
  endtask

  // Receive side: random stalls drawn per result word.
  initial begin
    int unsigned hold;
    bit eager;
    hold = 0;
    eager = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        tracker.compare_word(granted, offset, status);
        if ($urandom_range(0, 39) == 0) eager = !eager;
        hold = draw_gap(eager);
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, directed words, then random phases per capacity.
  initial begin
    logic [16:0] cap_plan [9];
    tracker = new();
    cap_plan = '{17'd7, 17'd1, 17'd0, AMOUNT_ALL_ONES, 17'd16, 17'd300, 17'd65535,
                 17'd2, 17'd0};
    cap_plan[7] = 17'($urandom_range(2, 64));
    cap_plan[8] = 17'($urandom_range(65, 4096));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset capacity: field extremes, full-ring claims,
    // oversized acks, ack of zero, unused kinds and a counter clear.
    send_word(KIND_PUT_CLAIM, '0);
    send_word(KIND_GET_CLAIM, AMOUNT_ALL_ONES);
    send_word(KIND_PUT_CLAIM, AMOUNT_ALL_ONES);
    send_word(KIND_PUT_ACK, 17'd65537);
    send_word(KIND_PUT_ACK, 17'd65536);
    send_word(KIND_GET_ACK, 17'd1);
    send_word(KIND_GET_CLAIM, AMOUNT_ALL_ONES);
    send_word(KIND_GET_ACK, 17'd65535);
    send_word(KIND_PUT_CLAIM, 17'd100);
    send_word(KIND_SPARE_LO, AMOUNT_ALL_ONES);
    send_word(KIND_SPARE_LO + 3'd1, '0);
    send_word(KIND_SPARE_HI, AMOUNT_ALL_ONES);
    send_word(KIND_PUT_ACK, '0);
    send_word(KIND_CLEAR, AMOUNT_ALL_ONES);
    send_word(KIND_PUT_CLAIM, 17'd1);
    drain();

    // Zero capacity behaves as a ring of one byte.
    write_capacity('0);
    send_word(KIND_CLEAR, '0);
    send_word(KIND_PUT_CLAIM, 17'd5);
    send_word(KIND_PUT_ACK, 17'd1);
    send_word(KIND_GET_CLAIM, 17'd3);
    send_word(KIND_GET_ACK, 17'd2);
    send_word(KIND_GET_ACK, 17'd1);
    send_word(KIND_PUT_CLAIM, 17'd1);
    drain();

    // Random phases; odd phases keep the old counters across the capacity change.
    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      if (p % 2 == 0) send_word(KIND_CLEAR, 17'($urandom() & AMOUNT_ALL_ONES));
      for (int i = 0; i < 133; i++) begin
        if (p == 4 && i == 66) drain();
        send_random_word();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (tracker.owed_q.size() != 0) begin
      $error("%0d result words never arrived", tracker.owed_q.size());
      tracker.errors++;
    end

    $display("Ran %0d words: %0d claims, %0d acks (%0d rejected) over %0d capacity settings,",
             tracker.words, tracker.claims, tracker.acks, tracker.rejects, settings);
    $display("with random idling and stalls on both channels and %0d cycles used.", cycle_count);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
